// File: sv/hsi_cs_pkg.sv
package hsi_cs_pkg;

   localparam int FRAC_BITS = 12;
   localparam int ONE       = 1 << FRAC_BITS;
   localparam int TURN      = 6 * ONE;

   localparam int HUE_W   = 15;
   localparam int LVL_W   = 13;
   localparam int CH_W    = 8;
   localparam int PURE_W  = FRAC_BITS + 1;
   localparam int INNER_W = 2 * FRAC_BITS + 1;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   typedef enum logic [2:0] {
      CSR_START_HUE = 3'd0,
      CSR_START_SAT = 3'd1,
      CSR_START_INT = 3'd2,
      CSR_END_HUE   = 3'd3,
      CSR_END_SAT   = 3'd4,
      CSR_END_INT   = 3'd5
   } csr_index_type;

   localparam logic [63:0] Q30_ONE = 64'd1 << 30;
   localparam logic [63:0] PI_Q30  = 64'd3373259426;

   // (2k-1)*(2k) for the Taylor terms of cosine
   localparam logic [63:0] TAYLOR_DIV [8] = '{
      64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240
   };

   // Cosine on [0, pi/2], angle and result in Q30; evaluated at elaboration only.
   function automatic logic [63:0] cos_quarter_q30(input logic [63:0] x);
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [65:0] sum;
      x2   = (x * x) >> 30;
      term = Q30_ONE;
      sum  = $signed({2'b00, Q30_ONE});
      for (int k = 1; k <= 8; k++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[k-1];
         if ((k % 2) == 1) begin
            sum = sum - $signed({2'b00, term});
         end else begin
            sum = sum + $signed({2'b00, term});
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      if (sum > $signed({2'b00, Q30_ONE})) begin
         sum = $signed({2'b00, Q30_ONE});
      end
      return sum[63:0];
   endfunction

   // (1 +/- cos)/2 at quarter-wave position m, rounded to FRAC_BITS
   function automatic logic [PURE_W-1:0] pure_lut(input int m, input int ctb,
                                                 input logic neg);
      logic [63:0] x;
      logic [63:0] c;
      logic [63:0] pq;
      logic [63:0] r;
      x  = (64'd2 * PI_Q30 * 64'(m)) >> ctb;
      c  = cos_quarter_q30(x);
      pq = neg ? ((Q30_ONE - c) >> 1) : ((Q30_ONE + c) >> 1);
      r  = (pq + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
      return r[PURE_W-1:0];
   endfunction

endpackage

// File: sv/hsi_cs_pure.sv
module hsi_cs_pure import hsi_cs_pkg::*; #(
   parameter int COS_TABLE_BITS = 10,
   parameter int PHASE_SIXTHS   = 0
) (
   input  logic              clock,
   input  logic [HUE_W-1:0]  hue,
   output logic [PURE_W-1:0] pure_out
);

   localparam int N       = 1 << COS_TABLE_BITS;
   localparam int QTR     = N / 4;
   localparam int TW      = HUE_W + COS_TABLE_BITS - FRAC_BITS - 1;
   localparam int RSHIFT  = TW + 2;
   localparam int RECIP   = ((1 << RSHIFT) + 2) / 3;
   localparam int PW      = 2 * TW + 1;
   localparam int MW      = COS_TABLE_BITS - 1;

   logic [PURE_W-1:0] pos_rom [0:QTR];
   logic [PURE_W-1:0] neg_rom [0:QTR];

   for (genvar g = 0; g <= QTR; g++) begin : g_rom
      assign pos_rom[g] = pure_lut(g, COS_TABLE_BITS, 1'b0);
      assign neg_rom[g] = pure_lut(g, COS_TABLE_BITS, 1'b1);
   end

   logic [HUE_W:0]                  phase_sum;
   logic [HUE_W-1:0]                phase;
   logic [HUE_W+COS_TABLE_BITS-1:0] phase_scaled;
   logic [TW-1:0]                   sector;
   logic [PW-1:0]                   prod_in;
   logic [PW-1:0]                   prod_ff;

   // phase index = phase * N / TURN, as (phase * N / 2^(F+1)) / 3
   always_comb begin
      phase_sum = {1'b0, hue} + (HUE_W+1)'(PHASE_SIXTHS * ONE);
      if (phase_sum >= (HUE_W+1)'(TURN)) begin
         phase = HUE_W'(phase_sum - (HUE_W+1)'(TURN));
      end else begin
         phase = phase_sum[HUE_W-1:0];
      end
      phase_scaled = {phase, {COS_TABLE_BITS{1'b0}}};
      sector       = phase_scaled[FRAC_BITS+1 +: TW];
      prod_in      = PW'(sector) * PW'(RECIP);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   logic [COS_TABLE_BITS-1:0] idx;
   logic [COS_TABLE_BITS-1:0] half_m;
   logic [COS_TABLE_BITS:0]   wrap_m;
   logic [MW-1:0]             quarter_m;
   logic [COS_TABLE_BITS-1:0] flip_m;
   logic                      neg;
   logic [PURE_W-1:0]         pure_in;
   logic [PURE_W-1:0]         pure_ff;

   // fold the full turn onto a quarter wave
   always_comb begin
      idx    = prod_ff[RSHIFT +: COS_TABLE_BITS];
      wrap_m = (COS_TABLE_BITS+1)'(N) - {1'b0, idx};
      if (idx > COS_TABLE_BITS'(N / 2)) begin
         half_m = wrap_m[COS_TABLE_BITS-1:0];
      end else begin
         half_m = idx;
      end
      flip_m = COS_TABLE_BITS'(N / 2) - half_m;
      neg    = half_m > COS_TABLE_BITS'(QTR);
      if (neg) begin
         quarter_m = flip_m[MW-1:0];
         pure_in   = neg_rom[quarter_m];
      end else begin
         quarter_m = half_m[MW-1:0];
         pure_in   = pos_rom[quarter_m];
      end
   end

   always_ff @(posedge clock) begin
      pure_ff <= pure_in;
   end

   assign pure_out = pure_ff;

endmodule

// File: sv/hsi_color_scale_to_rgb_top.sv
// HSI color-scale to RGB. Each fraction on req_fraction (4096 = 1.0) is mapped to
// a color between the programmed start and end HSI colors; the hue runs forward
// from start to end around the color wheel. The block takes one item every clock
// cycle while busy is low and returns its red, green and blue bytes with
// rsp_strobe high for one cycle; the result must be taken in that cycle. The
// datapath has seven register stages: interpolation multiply, hue/level sum,
// phase scaling multiply, cosine table, two channel multiplies and the final 255
// scale. busy is high during reset and in the cycle after it, and in the cycle
// after each register write, while the derived configuration settles;
// write registers only while no item is in flight.
module hsi_color_scale_to_rgb_top import hsi_cs_pkg::*; #(
   parameter int COS_TABLE_BITS = 10
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [LVL_W-1:0]      req_fraction,
   output logic                  rsp_strobe,
   output logic [CH_W-1:0]       rsp_red,
   output logic [CH_W-1:0]       rsp_green,
   output logic [CH_W-1:0]       rsp_blue,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int STAGES = 7;
   localparam int HRF_W  = HUE_W + LVL_W;
   localparam int LP_W   = 2 * LVL_W;
   localparam int IP_W   = LVL_W + INNER_W;
   localparam int SC_W   = IP_W + 8;
   localparam int V_W    = SC_W - 3 * FRAC_BITS;

   // ---------------------------------------------------------------- registers
   logic                  csr_write;
   csr_index_type         csr_index;
   logic [HUE_W-1:0]      start_hue_ff, end_hue_ff;
   logic [LVL_W-1:0]      start_sat_ff, start_int_ff, end_sat_ff, end_int_ff;
   logic                  busy_ff;

   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_index_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_hue_ff <= '0;
         start_sat_ff <= LVL_W'(ONE);
         start_int_ff <= LVL_W'(ONE);
         end_hue_ff   <= HUE_W'(4 * ONE);
         end_sat_ff   <= LVL_W'(ONE);
         end_int_ff   <= LVL_W'(ONE);
         busy_ff      <= 1'b1;
      end else begin
         busy_ff <= csr_write;
         if (csr_write) begin
            case (csr_index)
               CSR_START_HUE: start_hue_ff <= csr_pwdata[HUE_W-1:0];
               CSR_START_SAT: start_sat_ff <= csr_pwdata[LVL_W-1:0];
               CSR_START_INT: start_int_ff <= csr_pwdata[LVL_W-1:0];
               CSR_END_HUE:   end_hue_ff   <= csr_pwdata[HUE_W-1:0];
               CSR_END_SAT:   end_sat_ff   <= csr_pwdata[LVL_W-1:0];
               CSR_END_INT:   end_int_ff   <= csr_pwdata[LVL_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_comb begin
      case (csr_index)
         CSR_START_HUE: csr_prdata = CSR_DATA_W'(start_hue_ff);
         CSR_START_SAT: csr_prdata = CSR_DATA_W'(start_sat_ff);
         CSR_START_INT: csr_prdata = CSR_DATA_W'(start_int_ff);
         CSR_END_HUE:   csr_prdata = CSR_DATA_W'(end_hue_ff);
         CSR_END_SAT:   csr_prdata = CSR_DATA_W'(end_sat_ff);
         CSR_END_INT:   csr_prdata = CSR_DATA_W'(end_int_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign busy = busy_ff;

   // ------------------------------------------------------ derived configuration
   logic [HUE_W-1:0] sh_in, eh_in, hr_in, sh_ff, hr_ff;
   logic [HUE_W:0]   hr_wide;
   logic [LVL_W-1:0] ss_in, es_in, si_in, ei_in, ss_ff, es_ff, si_ff, ei_ff;

   always_comb begin
      sh_in = (start_hue_ff >= HUE_W'(TURN)) ? start_hue_ff - HUE_W'(TURN) : start_hue_ff;
      eh_in = (end_hue_ff >= HUE_W'(TURN)) ? end_hue_ff - HUE_W'(TURN) : end_hue_ff;
      if (eh_in >= sh_in) begin
         hr_wide = {1'b0, eh_in - sh_in};
      end else begin
         hr_wide = {1'b0, eh_in} + (HUE_W+1)'(TURN) - {1'b0, sh_in};
      end
      hr_in = hr_wide[HUE_W-1:0];
      ss_in = (start_sat_ff > LVL_W'(ONE)) ? LVL_W'(ONE) : start_sat_ff;
      es_in = (end_sat_ff > LVL_W'(ONE)) ? LVL_W'(ONE) : end_sat_ff;
      si_in = (start_int_ff > LVL_W'(ONE)) ? LVL_W'(ONE) : start_int_ff;
      ei_in = (end_int_ff > LVL_W'(ONE)) ? LVL_W'(ONE) : end_int_ff;
   end

   always_ff @(posedge clock) begin
      sh_ff <= sh_in;
      hr_ff <= hr_in;
      ss_ff <= ss_in;
      es_ff <= es_in;
      si_ff <= si_in;
      ei_ff <= ei_in;
   end

   // ------------------------------------------------------------ valid tracking
   logic              accept;
   logic [STAGES-1:0] vld_ff;

   assign accept = start && !busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[STAGES-2:0], accept};
      end
   end

   assign rsp_strobe = vld_ff[STAGES-1];

   // ----------------------------------------------- stage 1: interpolation products
   logic [LVL_W-1:0] f_c, f_inv;
   logic [HRF_W-1:0] hrf_in, hrf_ff;
   logic [LP_W-1:0]  sa_in, sb_in, ia_in, ib_in, sa_ff, sb_ff, ia_ff, ib_ff;

   always_comb begin
      f_c    = (req_fraction > LVL_W'(ONE)) ? LVL_W'(ONE) : req_fraction;
      f_inv  = LVL_W'(ONE) - f_c;
      hrf_in = HRF_W'(hr_ff) * HRF_W'(f_c);
      sa_in  = LP_W'(ss_ff) * LP_W'(f_inv);
      sb_in  = LP_W'(es_ff) * LP_W'(f_c);
      ia_in  = LP_W'(si_ff) * LP_W'(f_inv);
      ib_in  = LP_W'(ei_ff) * LP_W'(f_c);
   end

   always_ff @(posedge clock) begin
      hrf_ff <= hrf_in;
      sa_ff  <= sa_in;
      sb_ff  <= sb_in;
      ia_ff  <= ia_in;
      ib_ff  <= ib_in;
   end

   // ------------------------------------------------ stage 2: hue, sat, intensity
   logic [HRF_W:0]      hue_sum;
   logic [HUE_W:0]      hue_q;
   logic [HUE_W-1:0]    hue_in, hue_ff;
   logic [LP_W:0]       s_sum, i_sum;
   logic [LVL_W-1:0]    s2_in, i2_in, s2_ff, i2_ff;

   always_comb begin
      hue_sum = (HRF_W+1)'({sh_ff, {FRAC_BITS{1'b0}}}) + (HRF_W+1)'(hrf_ff);
      hue_q   = hue_sum[FRAC_BITS +: HUE_W+1];
      if (hue_q >= (HUE_W+1)'(TURN)) begin
         hue_in = HUE_W'(hue_q - (HUE_W+1)'(TURN));
      end else begin
         hue_in = hue_q[HUE_W-1:0];
      end
      s_sum = {1'b0, sa_ff} + {1'b0, sb_ff};
      i_sum = {1'b0, ia_ff} + {1'b0, ib_ff};
      s2_in = s_sum[FRAC_BITS +: LVL_W];
      i2_in = i_sum[FRAC_BITS +: LVL_W];
   end

   always_ff @(posedge clock) begin
      hue_ff <= hue_in;
      s2_ff  <= s2_in;
      i2_ff  <= i2_in;
   end

   // ------------------------------------------ stages 3 and 4: cosine per channel
   logic [PURE_W-1:0] pure_val [3];

   hsi_cs_pure #(.COS_TABLE_BITS(COS_TABLE_BITS), .PHASE_SIXTHS(0)) u_pure_red (
      .clock    (clock),
      .hue      (hue_ff),
      .pure_out (pure_val[0])
   );

   hsi_cs_pure #(.COS_TABLE_BITS(COS_TABLE_BITS), .PHASE_SIXTHS(4)) u_pure_green (
      .clock    (clock),
      .hue      (hue_ff),
      .pure_out (pure_val[1])
   );

   hsi_cs_pure #(.COS_TABLE_BITS(COS_TABLE_BITS), .PHASE_SIXTHS(2)) u_pure_blue (
      .clock    (clock),
      .hue      (hue_ff),
      .pure_out (pure_val[2])
   );

   logic [LVL_W-1:0] s3_ff, s4_ff, i3_ff, i4_ff, i5_ff;

   always_ff @(posedge clock) begin
      s3_ff <= s2_ff;
      s4_ff <= s3_ff;
      i3_ff <= i2_ff;
      i4_ff <= i3_ff;
      i5_ff <= i4_ff;
   end

   // --------------------------------------------- stages 5 to 7: channel values
   logic [INNER_W-1:0] inner_in [3];
   logic [INNER_W-1:0] inner_ff [3];
   logic [IP_W-1:0]    ip_in [3];
   logic [IP_W-1:0]    ip_ff [3];
   logic [SC_W-1:0]    scaled [3];
   logic [V_W-1:0]     v_raw [3];
   logic [CH_W-1:0]    ch_in [3];
   logic [CH_W-1:0]    ch_ff [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         inner_in[c] = INNER_W'(ONE * ONE)
                     - INNER_W'(s4_ff) * INNER_W'(PURE_W'(ONE) - pure_val[c]);
         ip_in[c]    = IP_W'(i5_ff) * IP_W'(inner_ff[c]);
         // times 255 as shift and subtract
         scaled[c]   = {ip_ff[c], 8'b0} - SC_W'(ip_ff[c]);
         v_raw[c]    = scaled[c][3*FRAC_BITS +: V_W];
         ch_in[c]    = (v_raw[c] > V_W'(255)) ? CH_W'(255) : v_raw[c][CH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         inner_ff[c] <= inner_in[c];
         ip_ff[c]    <= ip_in[c];
         ch_ff[c]    <= ch_in[c];
      end
   end

   assign rsp_red   = ch_ff[0];
   assign rsp_green = ch_ff[1];
   assign rsp_blue  = ch_ff[2];

   // ---------------------------------------------------------------- assertions
   a_busy_after_write: assert property (@(posedge clock) disable iff (reset)
      csr_write |=> busy)
      else $error("busy not raised after register write");

   a_accept_to_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##STAGES rsp_strobe)
      else $error("accepted item produced no result");

   a_strobe_from_accept: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, STAGES))
      else $error("result without matching transfer");

   a_hue_wrapped: assert property (@(posedge clock) disable iff (reset)
      vld_ff[1] |-> (hue_ff < HUE_W'(TURN)))
      else $error("interpolated hue not wrapped");

   a_inner_bound: assert property (@(posedge clock) disable iff (reset)
      vld_ff[4] |-> (inner_ff[0] <= INNER_W'(ONE * ONE)) && (s4_ff <= LVL_W'(ONE)))
      else $error("channel factor out of range");

endmodule
